// ===== rtl/idfmt_pkg.sv =====
`default_nettype none
package idfmt_pkg;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_CONV_MODE   = 3'd0;
  localparam logic [2:0] REG_LEFT_JUST   = 3'd1;
  localparam logic [2:0] REG_FORCE_SIGN  = 3'd2;
  localparam logic [2:0] REG_SPACE_SIGN  = 3'd3;
  localparam logic [2:0] REG_FIELD_WIDTH = 3'd4;
  localparam logic [2:0] REG_MIN_DIGITS  = 3'd5;

  // Conversion modes.
  localparam logic [2:0] MODE_S16 = 3'd0;
  localparam logic [2:0] MODE_S32 = 3'd1;
  localparam logic [2:0] MODE_S64 = 3'd2;
  localparam logic [2:0] MODE_U32 = 3'd3;
  localparam logic [2:0] MODE_U64 = 3'd4;

  localparam logic [6:0] FIELD_WIDTH_MAX = 7'd64;

  // Characters.
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  // A 64-bit magnitude has at most 20 decimal digits.
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned NUM_DIGITS = 20;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned NDIG_W     = 5;
  localparam int unsigned POS_W      = 7;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic norm_step;
    logic calc;
    logic emit;
  } idfmt_cmd_t;

  typedef struct packed {
    logic conv_last;
    logic norm_done;
    logic out_free;
    logic last_char;
  } idfmt_sts_t;

endpackage
`default_nettype wire

// ===== rtl/integer_decimal_field_formatter_top.sv =====
// Operation: the value is converted to BCD one bit per cycle, normalized by shifting out
// leading zero digits and then laid out; the characters then leave through the output register.
// Throughput: one character per cycle while the output channel accepts them.
// The next value is accepted once the last character of the field sits in the output reg.
// Reset (asynchronous, active low) restores all configuration registers and empties the
// output register; no clearing pass is needed.
`default_nettype none
module integer_decimal_field_formatter_top
  import idfmt_pkg::*;
#(
  parameter int unsigned MAX_FIELD = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration write port; the user must write it only while the block is idle (not enforced here).
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [6:0]         cfg_data_i,
  // Input channel: one raw value per beat.
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [VALUE_W-1:0] value_i,
  // Output channel: one character per beat, last marks the end of the field.
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              out_char_o,
  output logic                    last_o
);

  // The controller sequences the conversion, the digit-count search,
  // the layout computation and the character emission. The datapath holds
  // the configuration, the shift-and-add-3 converter and the output register.
  idfmt_cmd_t cmd;
  idfmt_sts_t sts;

  idfmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  idfmt_dp #(
    .MAX_FIELD (MAX_FIELD)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_o      (last_o)
  );

endmodule
`default_nettype wire

// ===== rtl/idfmt_ctrl.sv =====
`default_nettype none
module idfmt_ctrl
  import idfmt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire idfmt_sts_t sts_i,
  output idfmt_cmd_t      cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_NORM = 3'd2;
  localparam logic [2:0] ST_CALC = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv_step = 1'b1;
        if (sts_i.conv_last) begin
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if (sts_i.norm_done) begin
          state_d = ST_CALC;
        end else begin
          cmd_o.norm_step = 1'b1;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_char) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/idfmt_dp.sv =====
`default_nettype none
module idfmt_dp
  import idfmt_pkg::*;
#(
  parameter int unsigned MAX_FIELD = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [6:0]         cfg_data_i,
  input  wire logic [VALUE_W-1:0] value_i,
  input  wire idfmt_cmd_t         cmd_i,
  output idfmt_sts_t              sts_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              out_char_o,
  output logic                    last_o
);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_FIELD - 1);

  // Configuration registers.
  logic [2:0] mode_q;
  logic       left_q;
  logic       force_q;
  logic       space_q;
  logic [6:0] fw_q;
  logic [5:0] md_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_S32;
      left_q  <= 1'b0;
      force_q <= 1'b0;
      space_q <= 1'b0;
      fw_q    <= '0;
      md_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CONV_MODE:   mode_q  <= (cfg_data_i[2:0] > MODE_U64) ? MODE_U64 : cfg_data_i[2:0];
        REG_LEFT_JUST:   left_q  <= cfg_data_i[0];
        REG_FORCE_SIGN:  force_q <= cfg_data_i[0];
        REG_SPACE_SIGN:  space_q <= cfg_data_i[0];
        REG_FIELD_WIDTH: fw_q    <= (cfg_data_i > FIELD_WIDTH_MAX) ? FIELD_WIDTH_MAX
                                                                   : cfg_data_i;
        REG_MIN_DIGITS:  md_q    <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // Value extended to 64 bits (sign- or zero-extended by mode) and its magnitude.
  logic [VALUE_W-1:0] ext;
  logic               is_signed;
  logic               negative;
  logic [VALUE_W-1:0] mag;
  logic [7:0]         sign_char;
  logic               has_sign;

  always_comb begin
    case (mode_q)
      MODE_S16: ext = {{48{value_i[15]}}, value_i[15:0]};
      MODE_S32: ext = {{32{value_i[31]}}, value_i[31:0]};
      MODE_U32: ext = {32'd0, value_i[31:0]};
      default:  ext = value_i;
    endcase
    is_signed = (mode_q == MODE_S16) || (mode_q == MODE_S32) || (mode_q == MODE_S64);
    negative  = is_signed && ext[VALUE_W-1];
    mag       = negative ? (~ext + 64'd1) : ext;
    has_sign  = 1'b1;
    sign_char = CHAR_SPACE;
    if (negative) begin
      sign_char = CHAR_MINUS;
    end else if (is_signed && force_q) begin
      sign_char = CHAR_PLUS;
    end else if (is_signed && space_q) begin
      sign_char = CHAR_SPACE;
    end else begin
      has_sign = 1'b0;
    end
  end

  // Shift-and-add-3 binary to BCD conversion, one bit per cycle.
  logic [VALUE_W-1:0] bin_q;
  logic [BCD_W-1:0]   bcd_q;
  logic [BCD_W-1:0]   bcd_adj;
  logic [CNT_W-1:0]   cnt_q;
  logic [NDIG_W-1:0]  ndig_q;
  logic [7:0]         sign_q;
  logic               has_sign_q;

  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd_q[4*d +: 4] >= 4'd5) ? bcd_q[4*d +: 4] + 4'd3
                                                    : bcd_q[4*d +: 4];
    end
  end

  // Field layout boundaries in character positions.
  logic [5:0]       zeros;
  logic [POS_W-1:0] total;
  logic [POS_W-1:0] pad;
  logic [POS_W-1:0] b1_d, b2_d, b3_d, b4_d, end_d;
  logic [POS_W-1:0] b1_q, b2_q, b3_q, b4_q, end_q;
  logic [POS_W-1:0] pos_q;

  always_comb begin
    zeros = (md_q > {1'b0, ndig_q}) ? md_q - {1'b0, ndig_q} : 6'd0;
    total = {6'd0, has_sign_q} + {1'b0, zeros} + {2'd0, ndig_q};
    pad   = (fw_q > total) ? fw_q - total : 7'd0;
    b1_d  = left_q ? 7'd0 : pad;
    b2_d  = b1_d + {6'd0, has_sign_q};
    b3_d  = b2_d + {1'b0, zeros};
    b4_d  = b3_d + {2'd0, ndig_q};
    end_d = b4_d + (left_q ? pad : 7'd0);
  end

  logic [7:0] char_d;
  logic       in_digits;

  always_comb begin
    in_digits = 1'b0;
    if (pos_q < b1_q) begin
      char_d = CHAR_SPACE;
    end else if (pos_q < b2_q) begin
      char_d = sign_q;
    end else if (pos_q < b3_q) begin
      char_d = CHAR_ZERO;
    end else if (pos_q < b4_q) begin
      char_d    = CHAR_ZERO | {4'd0, bcd_q[BCD_W-1 -: 4]};
      in_digits = 1'b1;
    end else begin
      char_d = CHAR_SPACE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bin_q      <= mag;
      bcd_q      <= '0;
      cnt_q      <= '0;
      ndig_q     <= NDIG_W'(NUM_DIGITS);
      sign_q     <= sign_char;
      has_sign_q <= has_sign;
    end else if (cmd_i.conv_step) begin
      bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
      bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
      cnt_q <= cnt_q + 6'd1;
    end else if (cmd_i.norm_step) begin
      bcd_q  <= {bcd_q[BCD_W-5:0], 4'd0};
      ndig_q <= ndig_q - 5'd1;
    end else if (cmd_i.emit && in_digits) begin
      bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
    end
    if (cmd_i.calc) begin
      b1_q  <= b1_d;
      b2_q  <= b2_d;
      b3_q  <= b3_d;
      b4_q  <= b4_d;
      end_q <= end_d;
      pos_q <= '0;
    end else if (cmd_i.emit) begin
      pos_q <= pos_q + 7'd1;
    end
  end

  // Output register.
  logic       out_valid_q;
  logic [7:0] out_char_q;
  logic       out_last_q;
  logic       last_char;

  assign last_char = (pos_q + 7'd1 == end_q) || (pos_q == LAST_POS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_char_q <= char_d;
      out_last_q <= last_char;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_char_o      = out_char_q;
  assign last_o          = out_last_q;
  assign sts_o.conv_last = (cnt_q == 6'd63);
  assign sts_o.norm_done = (ndig_q == 5'd1) || (bcd_q[BCD_W-1 -: 4] != 4'd0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.last_char = last_char;

endmodule
`default_nettype wire
